// ===== hdl/mtep_pkg.sv =====
// shared types, status codes and helpers of the midi track event parser
package mtep_pkg;

    localparam int TickWidth = 63;
    localparam int VlqWidth  = 28;

    localparam logic [7:0] StSysex        = 8'hF0;
    localparam logic [7:0] StQuarterFrame = 8'hF1;
    localparam logic [7:0] StSongPosition = 8'hF2;
    localparam logic [7:0] StSongSelect   = 8'hF3;
    localparam logic [7:0] StSysexEscape  = 8'hF7;
    localparam logic [7:0] StMeta         = 8'hFF;
    localparam logic [7:0] StNone         = 8'h00;
    localparam logic [3:0] KindProgram    = 4'hC;
    localparam logic [3:0] KindPressure   = 4'hD;
    localparam logic [3:0] KindSystem     = 4'hF;
    localparam logic [2:0] VlqMaxBytes    = 3'd4;

    localparam logic [TickWidth-1:0] TickMax = {TickWidth{1'b1}};

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [TickWidth-1:0] event_tick;
        logic [7:0]           status_byte;
        logic [7:0]           first_data;
        logic [7:0]           second_data;
        logic                 end_marker;
        logic                 stopped_early;
    } out_item_t;

    // number of data bytes that follow a status byte
    function automatic logic [1:0] data_count(input logic [7:0] st);
        logic [1:0] n;
        if (st[7:4] == KindSystem) begin
            if (st == StQuarterFrame || st == StSongSelect) begin
                n = 2'd1;
            end
            else if (st == StSongPosition) begin
                n = 2'd2;
            end
            else begin
                n = 2'd0;
            end
        end
        else if (st[7:4] == KindProgram || st[7:4] == KindPressure) begin
            n = 2'd1;
        end
        else begin
            n = 2'd2;
        end
        return n;
    endfunction

endpackage

// ===== hdl/mtep_chan_if.sv =====
// valid/ready channel carrying one item of a given payload type
interface mtep_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/midi_track_event_parser_top.sv =====
// midi track event parser: bytes of one track chunk in, decoded events out
//
// Takes one chunk byte per cycle while the event output is not stalled, with
// last_byte set on the final byte. A byte is captured in an input register and
// decoded from there into at most two results (the event it completes, then the
// end marker on the final byte), which go into a three-entry result queue.
// Results leave at one per cycle while the sink is ready, so a byte is taken
// whenever the queue holds at most one result; a byte that yields both an event
// and the end marker holds back the next byte. With an empty queue a result
// reaches the output through the input register and then the queue.
// Delta times add into a 63-bit tick that saturates; a malformed or truncated
// event stops decoding until the final byte, whose end marker then carries
// stopped_early.
module midi_track_event_parser_top
    import mtep_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    mtep_chan_if.sink   byte_chan,
    mtep_chan_if.source event_chan
);

    typedef enum logic [3:0] {
        PH_DELTA,
        PH_STATUS,
        PH_METATYPE,
        PH_LENGTH,
        PH_SKIP,
        PH_DATA
    } phase_t;

    localparam int QueueDepth = 3;

    // input register
    logic       stage_valid_reg, stage_valid_next;
    logic [7:0] stage_byte_reg, stage_byte_next;
    logic       stage_last_reg, stage_last_next;

    // parser state
    logic [TickWidth-1:0] tick_reg, tick_next;
    logic [7:0]           run_status_reg, run_status_next;
    phase_t               phase_reg, phase_next;
    logic [VlqWidth-1:0]  vlq_acc_reg, vlq_acc_next;
    logic [2:0]           vlq_cnt_reg, vlq_cnt_next;
    logic [VlqWidth-1:0]  skip_reg, skip_next;
    logic [7:0]           held_status_reg, held_status_next;
    logic [7:0]           held_first_reg, held_first_next;
    logic [1:0]           data_needed_reg, data_needed_next;
    logic                 halted_reg, halted_next;

    // result queue, head at entry 0
    out_item_t  q_reg [QueueDepth];
    out_item_t  q_next [QueueDepth];
    out_item_t  q_shift [QueueDepth];
    logic [1:0] cnt_reg, cnt_next;

    logic       consume;
    logic       pop;
    logic [1:0] base;
    logic [1:0] push_n;
    out_item_t  push_a;
    out_item_t  push_b;

    logic                ev;
    out_item_t           ev_item;
    out_item_t           end_item;
    logic [7:0]          b;
    logic [VlqWidth-1:0] vlq_sum;
    logic [2:0]          vlq_cnt_inc;
    logic [TickWidth:0]  tick_sum;
    logic [1:0]          w;

    assign consume         = stage_valid_reg && (cnt_reg <= 2'd1);
    assign byte_chan.ready = !stage_valid_reg || consume;
    assign pop             = event_chan.valid && event_chan.ready;
    assign event_chan.valid   = (cnt_reg != 2'd0);
    assign event_chan.payload = q_reg[0];

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_byte_next  = stage_byte_reg;
        stage_last_next  = stage_last_reg;
        if (byte_chan.valid && byte_chan.ready) begin
            stage_valid_next = 1'b1;
            stage_byte_next  = byte_chan.payload.byte_value;
            stage_last_next  = byte_chan.payload.last_byte;
        end
        else if (consume) begin
            stage_valid_next = 1'b0;
        end
    end

    // decode of the byte held in the input register
    always_comb
    begin
        b                = stage_byte_reg;
        tick_next        = tick_reg;
        run_status_next  = run_status_reg;
        phase_next       = phase_reg;
        vlq_acc_next     = vlq_acc_reg;
        vlq_cnt_next     = vlq_cnt_reg;
        skip_next        = skip_reg;
        held_status_next = held_status_reg;
        held_first_next  = held_first_reg;
        data_needed_next = data_needed_reg;
        halted_next      = halted_reg;
        ev               = 1'b0;
        ev_item          = '0;
        end_item         = '0;
        vlq_sum     = {vlq_acc_reg[VlqWidth-8:0], b[6:0]};
        vlq_cnt_inc = vlq_cnt_reg + 3'd1;
        tick_sum    = {1'b0, tick_reg} + {{(TickWidth+1-VlqWidth){1'b0}}, vlq_sum};
        w           = data_count(held_status_reg);

        if (!halted_reg) begin
            case (phase_reg)
                PH_DELTA:
                begin
                    vlq_acc_next = vlq_sum;
                    vlq_cnt_next = vlq_cnt_inc;
                    if (!b[7]) begin
                        tick_next    = tick_sum[TickWidth] ? TickMax : tick_sum[TickWidth-1:0];
                        vlq_acc_next = '0;
                        vlq_cnt_next = '0;
                        phase_next   = PH_STATUS;
                    end
                    else if (vlq_cnt_inc >= VlqMaxBytes) begin
                        halted_next = 1'b1;
                    end
                end
                PH_STATUS:
                begin
                    if (!b[7]) begin
                        // data byte: running status
                        if (run_status_reg == StNone) begin
                            halted_next = 1'b1;
                        end
                        else begin
                            held_status_next = run_status_reg;
                            if (data_count(run_status_reg) == 2'd1) begin
                                ev                  = 1'b1;
                                ev_item.status_byte = run_status_reg;
                                ev_item.first_data  = b;
                                phase_next          = PH_DELTA;
                            end
                            else begin
                                held_first_next  = b;
                                data_needed_next = 2'd1;
                                phase_next       = PH_DATA;
                            end
                        end
                    end
                    else begin
                        if (b[7:4] != KindSystem) begin
                            run_status_next = b;
                        end
                        held_status_next = b;
                        held_first_next  = '0;
                        if (b == StMeta) begin
                            phase_next = PH_METATYPE;
                        end
                        else if (b inside {StSysex, StSysexEscape}) begin
                            phase_next = PH_LENGTH;
                        end
                        else if (data_count(b) == 2'd0) begin
                            ev                  = 1'b1;
                            ev_item.status_byte = b;
                            phase_next          = PH_DELTA;
                        end
                        else begin
                            data_needed_next = data_count(b);
                            phase_next       = PH_DATA;
                        end
                    end
                end
                PH_METATYPE:
                begin
                    held_first_next = b;
                    phase_next      = PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    vlq_acc_next = vlq_sum;
                    vlq_cnt_next = vlq_cnt_inc;
                    if (!b[7]) begin
                        skip_next    = vlq_sum;
                        vlq_acc_next = '0;
                        vlq_cnt_next = '0;
                        if (vlq_sum == '0) begin
                            ev                  = 1'b1;
                            ev_item.status_byte = held_status_reg;
                            ev_item.first_data  = held_first_reg;
                            phase_next          = PH_DELTA;
                        end
                        else begin
                            phase_next = PH_SKIP;
                        end
                    end
                    else if (vlq_cnt_inc >= VlqMaxBytes) begin
                        halted_next = 1'b1;
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_reg - VlqWidth'(1);
                    if (skip_reg == VlqWidth'(1)) begin
                        ev                  = 1'b1;
                        ev_item.status_byte = held_status_reg;
                        ev_item.first_data  = held_first_reg;
                        phase_next          = PH_DELTA;
                    end
                end
                PH_DATA:
                begin
                    if (w == 2'd2 && data_needed_reg == 2'd2) begin
                        held_first_next  = b;
                        data_needed_next = 2'd1;
                    end
                    else begin
                        ev                  = 1'b1;
                        ev_item.status_byte = held_status_reg;
                        if (w == 2'd2) begin
                            ev_item.first_data  = held_first_reg;
                            ev_item.second_data = b;
                        end
                        else begin
                            ev_item.first_data = b;
                        end
                        data_needed_next = '0;
                        phase_next       = PH_DELTA;
                    end
                end
                default:
                begin
                    halted_next = 1'b1;
                end
            endcase
        end

        ev_item.event_tick     = tick_next;
        end_item.event_tick    = tick_next;
        end_item.end_marker    = 1'b1;
        end_item.stopped_early = halted_next || (phase_next != PH_DELTA) ||
                                 (vlq_cnt_next != 3'd0);

        if (stage_last_reg) begin
            tick_next        = '0;
            run_status_next  = StNone;
            phase_next       = PH_DELTA;
            vlq_acc_next     = '0;
            vlq_cnt_next     = '0;
            skip_next        = '0;
            held_status_next = '0;
            held_first_next  = '0;
            data_needed_next = '0;
            halted_next      = 1'b0;
        end
    end

    // result queue update
    always_comb
    begin
        push_a = ev ? ev_item : end_item;
        push_b = end_item;
        push_n = '0;
        if (consume) begin
            push_n = {1'b0, ev} + {1'b0, stage_last_reg};
        end
        base = cnt_reg - {1'b0, pop};

        q_shift[0] = pop ? q_reg[1] : q_reg[0];
        q_shift[1] = pop ? q_reg[2] : q_reg[1];
        q_shift[2] = q_reg[2];

        for (int i = 0; i < QueueDepth; i++) begin
            q_next[i] = q_shift[i];
            if (push_n != 2'd0 && base == 2'(i)) begin
                q_next[i] = push_a;
            end
            if (push_n == 2'd2 && (base + 2'd1) == 2'(i)) begin
                q_next[i] = push_b;
            end
        end
        cnt_next = base + push_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
            cnt_reg         <= '0;
            tick_reg        <= '0;
            run_status_reg  <= StNone;
            phase_reg       <= PH_DELTA;
            vlq_acc_reg     <= '0;
            vlq_cnt_reg     <= '0;
            skip_reg        <= '0;
            held_status_reg <= '0;
            held_first_reg  <= '0;
            data_needed_reg <= '0;
            halted_reg      <= 1'b0;
        end
        else begin
            stage_valid_reg <= stage_valid_next;
            cnt_reg         <= cnt_next;
            if (consume) begin
                tick_reg        <= tick_next;
                run_status_reg  <= run_status_next;
                phase_reg       <= phase_next;
                vlq_acc_reg     <= vlq_acc_next;
                vlq_cnt_reg     <= vlq_cnt_next;
                skip_reg        <= skip_next;
                held_status_reg <= held_status_next;
                held_first_reg  <= held_first_next;
                data_needed_reg <= data_needed_next;
                halted_reg      <= halted_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        stage_byte_reg <= stage_byte_next;
        stage_last_reg <= stage_last_next;
        for (int i = 0; i < QueueDepth; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        consume && stage_last_reg |=>
            phase_reg == PH_DELTA && !halted_reg && tick_reg == '0 && vlq_cnt_reg == 3'd0)
        else $error("parser state not cleared after final byte");

    a_early_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        event_chan.valid && event_chan.payload.stopped_early |-> event_chan.payload.end_marker)
        else $error("stopped_early set on an ordinary event");

    a_end_marker_clean: assert property (@(posedge clk) disable iff (!rst_n)
        event_chan.valid && event_chan.payload.end_marker |->
            event_chan.payload.status_byte == StNone && event_chan.payload.first_data == 8'h00)
        else $error("end marker carries event fields");

    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        consume && halted_reg && !stage_last_reg |=> cnt_reg == $past(cnt_reg) - $past({1'b0, pop}))
        else $error("result produced while stopped");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the midi track event parser with its own event decoder
module tb_top;
    import mtep_pkg::*;

    localparam int WatchdogLimit = 5000;
    localparam int RandomBytes   = 950;
    localparam int DrainCycles   = 8;

    typedef enum logic [2:0] {
        SEEK_DELTA,
        SEEK_STATUS,
        SEEK_META_TYPE,
        SEEK_LENGTH,
        SKIP_PAYLOAD,
        SEEK_DATA
    } parse_phase_e;

    typedef enum logic [1:0] {
        VLQ_MORE,
        VLQ_DONE,
        VLQ_TOO_LONG
    } vlq_res_e;

    typedef struct {
        in_item_t item;
        logic     hold;
    } pending_byte_t;

    logic clk = 1'b0;
    logic rst_n;

    mtep_chan_if #(.payload_t(in_item_t))  byte_chan ();
    mtep_chan_if #(.payload_t(out_item_t)) event_chan ();

    midi_track_event_parser_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_chan  (byte_chan),
        .event_chan (event_chan)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // decoder state
    logic [TickWidth-1:0] p_tick;
    logic [7:0]           p_run_status;
    parse_phase_e         p_phase;
    logic [VlqWidth-1:0]  p_vlq_acc;
    logic [2:0]           p_vlq_cnt;
    logic [VlqWidth-1:0]  p_skip_left;
    logic [7:0]           p_held_st;
    logic [7:0]           p_held_d1;
    logic [1:0]           p_need;
    logic                 p_halted;

    out_item_t     expected_events[$];
    pending_byte_t pending_bytes[$];
    logic [7:0]    chunk_buf[$];

    int  fail_count  = 0;
    int  idle_cycles = 0;
    int  gap_left    = 0;
    int  stall_left  = 0;
    bit  byte_sent   = 1'b0;
    bit  src_calm    = 1'b0;
    bit  sink_calm   = 1'b0;

    out_item_t exp_ev;
    out_item_t got_ev;

    function automatic logic [1:0] msg_data_bytes(input logic [7:0] st);
        logic [1:0] n;
        if (st >= StSysex) begin
            if (st == StQuarterFrame || st == StSongSelect) begin
                n = 2'd1;
            end
            else if (st == StSongPosition) begin
                n = 2'd2;
            end
            else begin
                n = 2'd0;
            end
        end
        else if (st[7:4] == KindProgram || st[7:4] == KindPressure) begin
            n = 2'd1;
        end
        else begin
            n = 2'd2;
        end
        return n;
    endfunction

    function automatic out_item_t make_event(input logic [TickWidth-1:0] tick,
                                             input logic [7:0] st, input logic [7:0] d1,
                                             input logic [7:0] d2, input logic endm,
                                             input logic early);
        out_item_t ev;
        ev.event_tick    = tick;
        ev.status_byte   = st;
        ev.first_data    = d1;
        ev.second_data   = d2;
        ev.end_marker    = endm;
        ev.stopped_early = early;
        return ev;
    endfunction

    task automatic add_expected(input out_item_t ev);
        expected_events.insert(expected_events.size(), ev);
    endtask

    task automatic add_chunk_byte(input logic [7:0] val);
        chunk_buf.insert(chunk_buf.size(), val);
    endtask

    function automatic vlq_res_e vlq_step(input logic [7:0] b);
        vlq_res_e r;
        p_vlq_acc = {p_vlq_acc[VlqWidth-8:0], b[6:0]};
        p_vlq_cnt = p_vlq_cnt + 3'd1;
        if (!b[7]) begin
            r = VLQ_DONE;
        end
        else if (p_vlq_cnt >= VlqMaxBytes) begin
            r = VLQ_TOO_LONG;
        end
        else begin
            r = VLQ_MORE;
        end
        return r;
    endfunction

    task automatic reset_decoder();
        p_tick       = '0;
        p_run_status = StNone;
        p_phase      = SEEK_DELTA;
        p_vlq_acc    = '0;
        p_vlq_cnt    = '0;
        p_skip_left  = '0;
        p_held_st    = StNone;
        p_held_d1    = 8'h00;
        p_need       = 2'd0;
        p_halted     = 1'b0;
    endtask

    task automatic decode_byte(input in_item_t it);
        logic [7:0] b;
        vlq_res_e   r;
        logic [1:0] w;
        logic       early;
        b = it.byte_value;
        if (!p_halted) begin
            case (p_phase)
                SEEK_DELTA:
                begin
                    r = vlq_step(b);
                    if (r == VLQ_TOO_LONG) begin
                        p_halted = 1'b1;
                    end
                    else if (r == VLQ_DONE) begin
                        // saturating tick accumulation
                        if ({35'd0, p_vlq_acc} > TickMax - p_tick) begin
                            p_tick = TickMax;
                        end
                        else begin
                            p_tick = p_tick + {35'd0, p_vlq_acc};
                        end
                        p_vlq_acc = '0;
                        p_vlq_cnt = '0;
                        p_phase   = SEEK_STATUS;
                    end
                end
                SEEK_STATUS:
                begin
                    if (!b[7]) begin
                        if (p_run_status == StNone) begin
                            p_halted = 1'b1;
                        end
                        else begin
                            p_held_st = p_run_status;
                            w = msg_data_bytes(p_held_st);
                            if (w == 2'd1) begin
                                add_expected(
                                    make_event(p_tick, p_held_st, b, 8'h00, 1'b0, 1'b0));
                                p_phase = SEEK_DELTA;
                            end
                            else begin
                                p_held_d1 = b;
                                p_need    = 2'd1;
                                p_phase   = SEEK_DATA;
                            end
                        end
                    end
                    else begin
                        // only channel statuses update running status
                        if (b < StSysex) begin
                            p_run_status = b;
                        end
                        p_held_st = b;
                        p_held_d1 = 8'h00;
                        if (b == StMeta) begin
                            p_phase = SEEK_META_TYPE;
                        end
                        else if (b == StSysex || b == StSysexEscape) begin
                            p_phase = SEEK_LENGTH;
                        end
                        else begin
                            w = msg_data_bytes(b);
                            if (w == 2'd0) begin
                                add_expected(
                                    make_event(p_tick, b, 8'h00, 8'h00, 1'b0, 1'b0));
                                p_phase = SEEK_DELTA;
                            end
                            else begin
                                p_need  = w;
                                p_phase = SEEK_DATA;
                            end
                        end
                    end
                end
                SEEK_META_TYPE:
                begin
                    p_held_d1 = b;
                    p_phase   = SEEK_LENGTH;
                end
                SEEK_LENGTH:
                begin
                    r = vlq_step(b);
                    if (r == VLQ_TOO_LONG) begin
                        p_halted = 1'b1;
                    end
                    else if (r == VLQ_DONE) begin
                        p_skip_left = p_vlq_acc;
                        p_vlq_acc   = '0;
                        p_vlq_cnt   = '0;
                        if (p_skip_left == '0) begin
                            add_expected(
                                make_event(p_tick, p_held_st, p_held_d1, 8'h00, 1'b0, 1'b0));
                            p_phase = SEEK_DELTA;
                        end
                        else begin
                            p_phase = SKIP_PAYLOAD;
                        end
                    end
                end
                SKIP_PAYLOAD:
                begin
                    p_skip_left = p_skip_left - 1'b1;
                    if (p_skip_left == '0) begin
                        add_expected(
                            make_event(p_tick, p_held_st, p_held_d1, 8'h00, 1'b0, 1'b0));
                        p_phase = SEEK_DELTA;
                    end
                end
                SEEK_DATA:
                begin
                    w = msg_data_bytes(p_held_st);
                    if (w == 2'd2 && p_need == 2'd2) begin
                        p_held_d1 = b;
                        p_need    = 2'd1;
                    end
                    else begin
                        if (w == 2'd2) begin
                            add_expected(
                                make_event(p_tick, p_held_st, p_held_d1, b, 1'b0, 1'b0));
                        end
                        else begin
                            add_expected(
                                make_event(p_tick, p_held_st, b, 8'h00, 1'b0, 1'b0));
                        end
                        p_need  = 2'd0;
                        p_phase = SEEK_DELTA;
                    end
                end
                default:
                begin
                    p_halted = 1'b1;
                end
            endcase
        end
        if (it.last_byte) begin
            early = p_halted || (p_phase != SEEK_DELTA) || (p_vlq_cnt != 3'd0);
            add_expected(make_event(p_tick, StNone, 8'h00, 8'h00, 1'b1, early));
            reset_decoder();
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 1;
        end
        else if (r < 90) begin
            return $urandom_range(2, 4);
        end
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [7:0] data_value();
        if ($urandom_range(0, 15) == 0) begin
            return 8'($urandom_range(128, 255));
        end
        return 8'($urandom_range(0, 127));
    endfunction

    task automatic flush_chunk(input logic hold);
        pending_byte_t pb;
        for (int i = 0; i < chunk_buf.size(); i++) begin
            pb.item.byte_value = chunk_buf[i];
            pb.item.last_byte  = (i == chunk_buf.size() - 1);
            pb.hold            = hold && (i == 0);
            pending_bytes.insert(pending_bytes.size(), pb);
        end
        chunk_buf.delete();
    endtask

    task automatic push_vlq_random(input int nbytes);
        logic [7:0] b;
        for (int i = 0; i < nbytes; i++) begin
            b = 8'($urandom_range(0, 127));
            if (i < nbytes - 1) begin
                b[7] = 1'b1;
            end
            add_chunk_byte(b);
        end
    endtask

    // length field and the payload it announces
    task automatic push_payload();
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            len = $urandom_range(0, 4);
        end
        else if (r < 95) begin
            len = $urandom_range(5, 20);
        end
        else begin
            len = $urandom_range(21, 60);
        end
        if ($urandom_range(0, 7) == 0) begin
            add_chunk_byte(8'h80 | 8'(len >> 7));
        end
        add_chunk_byte(8'(len & 8'h7F));
        repeat (len) add_chunk_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic gen_event(inout logic [7:0] run_st);
        int         kind;
        int         dlen;
        logic [1:0] n;
        logic [7:0] st;
        kind = $urandom_range(0, 99);
        dlen = ($urandom_range(0, 9) < 6) ? 1 : $urandom_range(2, 4);
        if (kind >= 94) begin
            // broken events
            case ($urandom_range(0, 2))
                0:
                begin
                    repeat (4) add_chunk_byte(8'h80 | 8'($urandom_range(0, 127)));
                end
                1:
                begin
                    push_vlq_random(dlen);
                    add_chunk_byte(8'($urandom_range(0, 127)));
                end
                default:
                begin
                    push_vlq_random(dlen);
                    add_chunk_byte(($urandom_range(0, 1) == 0) ? StSysex : StMeta);
                    repeat (4) add_chunk_byte(8'h80 | 8'($urandom_range(0, 127)));
                end
            endcase
            return;
        end
        push_vlq_random(dlen);
        if (kind < 45) begin
            st = 8'($urandom_range(8'h80, 8'hEF));
            n  = msg_data_bytes(st);
            if (run_st != StNone && $urandom_range(0, 1) == 0) begin
                // running status: first data byte must look like data
                n = msg_data_bytes(run_st);
                add_chunk_byte(8'($urandom_range(0, 127)));
                if (n == 2'd2) begin
                    add_chunk_byte(data_value());
                end
            end
            else begin
                run_st = st;
                add_chunk_byte(st);
                repeat (n) add_chunk_byte(data_value());
            end
        end
        else if (kind < 60) begin
            case ($urandom_range(0, 3))
                0:       st = StQuarterFrame;
                1:       st = StSongPosition;
                2:       st = StSongSelect;
                default:
                begin
                    st = 8'($urandom_range(8'hF4, 8'hFE));
                    if (st == StSysexEscape) begin
                        st = 8'hF8;
                    end
                end
            endcase
            add_chunk_byte(st);
            repeat (msg_data_bytes(st)) add_chunk_byte(data_value());
        end
        else if (kind < 78) begin
            add_chunk_byte(StMeta);
            add_chunk_byte(8'($urandom_range(0, 255)));
            push_payload();
        end
        else begin
            add_chunk_byte(($urandom_range(0, 1) == 0) ? StSysex : StSysexEscape);
            push_payload();
        end
    endtask

    task automatic gen_chunk(input logic hold);
        logic [7:0] run_st;
        int         cut;
        run_st = StNone;
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 16)) add_chunk_byte(8'($urandom_range(0, 255)));
        end
        else begin
            repeat ($urandom_range(1, 10)) gen_event(run_st);
            if ($urandom_range(0, 3) != 0) begin
                // end of track meta
                add_chunk_byte(8'h00);
                add_chunk_byte(StMeta);
                add_chunk_byte(8'h2F);
                add_chunk_byte(8'h00);
            end
            if ($urandom_range(0, 6) == 0) begin
                cut = $urandom_range(1, chunk_buf.size());
                while (chunk_buf.size() > cut) void'(chunk_buf.pop_back());
            end
        end
        flush_chunk(hold);
    endtask

    // ------------------------------------------------------------------
    // byte driver
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && byte_chan.valid && byte_chan.ready) begin
            decode_byte(byte_chan.payload);
            void'(pending_bytes.pop_front());
            byte_sent = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0) begin
            src_calm = !src_calm;
        end
        if (rst_n && (!byte_chan.valid || byte_sent)) begin
            byte_sent = 1'b0;
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                byte_chan.valid <= 1'b0;
            end
            else if (pending_bytes.size() > 0 &&
                     !(pending_bytes[0].hold && expected_events.size() != 0)) begin
                byte_chan.valid   <= 1'b1;
                byte_chan.payload <= pending_bytes[0].item;
                gap_left = (src_calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
            end
            else begin
                byte_chan.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // event monitor
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0) begin
            sink_calm = !sink_calm;
        end
        if (rst_n) begin
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                event_chan.ready <= 1'b0;
            end
            else begin
                event_chan.ready <= 1'b1;
                if (!sink_calm && $urandom_range(0, 5) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && event_chan.valid && event_chan.ready) begin
            got_ev = event_chan.payload;
            if (expected_events.size() == 0) begin
                fail_count = fail_count + 1;
                if (fail_count <= 10) begin
                    $display("unexpected event: tick %0d status %h d1 %h d2 %h end %b early %b",
                             got_ev.event_tick, got_ev.status_byte, got_ev.first_data,
                             got_ev.second_data, got_ev.end_marker, got_ev.stopped_early);
                end
            end
            else begin
                exp_ev = expected_events.pop_front();
                if (got_ev.event_tick !== exp_ev.event_tick ||
                    got_ev.status_byte !== exp_ev.status_byte ||
                    got_ev.first_data !== exp_ev.first_data ||
                    got_ev.second_data !== exp_ev.second_data ||
                    got_ev.end_marker !== exp_ev.end_marker ||
                    got_ev.stopped_early !== exp_ev.stopped_early) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10) begin
                        $display("event mismatch (exp/got): tick %0d/%0d status %h/%h",
                                 exp_ev.event_tick, got_ev.event_tick,
                                 exp_ev.status_byte, got_ev.status_byte);
                        $display("    d1 %h/%h d2 %h/%h end %b/%b early %b/%b",
                                 exp_ev.first_data, got_ev.first_data,
                                 exp_ev.second_data, got_ev.second_data,
                                 exp_ev.end_marker, got_ev.end_marker,
                                 exp_ev.stopped_early, got_ev.stopped_early);
                    end
                end
            end
        end
    end

    // no item moving on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((byte_chan.valid && byte_chan.ready) ||
                (event_chan.valid && event_chan.ready)) begin
                idle_cycles = 0;
            end
            else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= WatchdogLimit) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        byte_chan.valid   = 1'b0;
        byte_chan.payload = '0;
        event_chan.ready  = 1'b0;
        rst_n             = 1'b0;
        reset_decoder();

        // note on, running status note, end of track with the final byte
        chunk_buf = '{8'h00, 8'h90, 8'h3C, 8'h7F, 8'h00, 8'h3C, 8'h00,
                      8'h00, StMeta, 8'h2F, 8'h00};
        flush_chunk(1'b0);
        // delta time longer than four bytes, then an ignored final byte
        chunk_buf = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        flush_chunk(1'b0);
        // data byte with no running status, on the final byte
        chunk_buf = '{8'h00, 8'h40};
        flush_chunk(1'b0);
        // two byte delta, song position with high data, sysex ending the chunk
        chunk_buf = '{8'h81, 8'h00, StSongPosition, 8'h01, 8'hFF,
                      8'h00, StSysex, 8'h01, 8'hAA};
        flush_chunk(1'b0);
        // chunk ends inside a delta time
        chunk_buf = '{8'h85};
        flush_chunk(1'b0);

        gen_chunk(1'b1);
        while (pending_bytes.size() < RandomBytes) begin
            gen_chunk($urandom_range(0, 19) == 0);
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || expected_events.size() != 0) begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);

        if (fail_count == 0) begin
            $display("Verification passed");
        end
        else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
